>>> design/bbvr_pkg.sv
// Shared types and constants of the bitplane bitmap video register block.
package bbvr_pkg;

  localparam int SCREEN_SIDE = 256;
  localparam int NUM_LANES   = 8;
  localparam int LANE_SEL_W  = $clog2(NUM_LANES);
  localparam int BANK_DEPTH  = SCREEN_SIDE * SCREEN_SIDE / NUM_LANES;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int PIX_W       = 3;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [15:0] ADDR_VIDEO_CTRL = 16'h1c00;
  localparam logic [15:0] ADDR_SCROLL_X   = 16'h1c01;
  localparam logic [15:0] ADDR_SCROLL_Y   = 16'h1c02;
  localparam logic [15:0] ADDR_CPU_CTRL   = 16'h1c03;
  // Bitmap window 0x2000-0x3fff is the page with address bits 15:13 equal to 1.
  localparam logic [2:0]  PLANE_PAGE      = 3'b001;

  localparam logic CFG_SWITCH_A = 1'b0;
  localparam logic CFG_SWITCH_B = 1'b1;

  localparam logic [7:0] SWITCH_A_RESET = 8'hdf;
  localparam logic [7:0] SWITCH_B_RESET = 8'hff;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FETCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } bus_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [BANK_AW-1:0] rd_addr;
    logic               wr_en;
    logic               clr;
    logic [BANK_AW-1:0] wr_addr;
    logic [PIX_W-1:0]   mask;
  } lane_req_t;

  typedef struct packed {
    logic       main_irq;
    logic       sub_irq;
    logic       frame_irq_en;
    logic [8:0] scroll_x;
    logic [8:0] scroll_y;
    logic       flip;
    logic       blue_low;
  } status_t;

endpackage

>>> design/bbvr_lane.sv
// One bitmap bank holding every eighth column, with its read-modify-write update.
module bbvr_lane import bbvr_pkg::*; (
  input  logic             clk_i,
  input  lane_req_t        req_i,
  input  logic             bit_i,
  output logic [PIX_W-1:0] rd_data_o
);

  logic [PIX_W-1:0] mem [BANK_DEPTH];
  logic [PIX_W-1:0] rd_data_q;
  logic [PIX_W-1:0] wr_data;

  // A set data bit adds the plane mask, a clear bit removes it; a clear request writes zero.
  always_comb begin
    if (req_i.clr) begin
      wr_data = '0;
    end else if (bit_i) begin
      wr_data = rd_data_q | req_i.mask;
    end else begin
      wr_data = rd_data_q & ~req_i.mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/bbvr_regs.sv
// Control registers, switch banks, configuration port and bus read decode.
module bbvr_regs import bbvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  bus_req_t           bus_req_i,
  input  logic [7:0]         port_zero_i,
  input  logic [7:0]         port_one_i,
  input  logic [7:0]         port_two_i,
  input  logic               vblank_now_i,
  output logic [7:0]         bus_rdata_o,
  output logic [PIX_W-1:0]   plane_mask_o,
  output logic               flip_o,
  output status_t            status_o
);

  logic [7:0] video_ctrl_q, video_ctrl_d;
  logic [7:0] cpu_ctrl_q, cpu_ctrl_d;
  logic [8:0] scroll_x_q, scroll_x_d;
  logic [8:0] scroll_y_q, scroll_y_d;
  logic [7:0] switch_a_q, switch_a_d;
  logic [7:0] switch_b_q, switch_b_d;
  logic       cfg_we;
  logic [PIX_W-1:0] inv_mask;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    switch_a_d = switch_a_q;
    switch_b_d = switch_b_q;
    if (cfg_we) begin
      case (paddr[PADDR_W-1])
        CFG_SWITCH_A: switch_a_d = pwdata[7:0];
        CFG_SWITCH_B: switch_b_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1])
      CFG_SWITCH_A: prdata = {{(PDATA_W-8){1'b0}}, switch_a_q};
      CFG_SWITCH_B: prdata = {{(PDATA_W-8){1'b0}}, switch_b_q};
      default:      prdata = '0;
    endcase
  end

  // The high scroll bits live in bit 0 of the video and CPU control registers.
  always_comb begin
    video_ctrl_d = video_ctrl_q;
    cpu_ctrl_d   = cpu_ctrl_q;
    scroll_x_d   = scroll_x_q;
    scroll_y_d   = scroll_y_q;
    if (bus_req_i.we) begin
      case (bus_req_i.addr)
        ADDR_VIDEO_CTRL: video_ctrl_d = bus_req_i.wdata;
        ADDR_SCROLL_X:   scroll_x_d   = {video_ctrl_q[0], bus_req_i.wdata};
        ADDR_SCROLL_Y:   scroll_y_d   = {cpu_ctrl_q[0], bus_req_i.wdata};
        ADDR_CPU_CTRL:   cpu_ctrl_d   = bus_req_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_ctrl_q <= '0;
      cpu_ctrl_q   <= '0;
      scroll_x_q   <= '0;
      scroll_y_q   <= '0;
      switch_a_q   <= SWITCH_A_RESET;
      switch_b_q   <= SWITCH_B_RESET;
    end else begin
      video_ctrl_q <= video_ctrl_d;
      cpu_ctrl_q   <= cpu_ctrl_d;
      scroll_x_q   <= scroll_x_d;
      scroll_y_q   <= scroll_y_d;
      switch_a_q   <= switch_a_d;
      switch_b_q   <= switch_b_d;
    end
  end

  always_comb begin
    case (bus_req_i.addr)
      ADDR_VIDEO_CTRL: bus_rdata_o = port_zero_i;
      ADDR_SCROLL_X:   bus_rdata_o = {vblank_now_i, port_one_i[6:0]};
      ADDR_SCROLL_Y:   bus_rdata_o = switch_a_q;
      ADDR_CPU_CTRL:   bus_rdata_o = {port_two_i[7:4], switch_b_q[3:0]};
      default:         bus_rdata_o = '0;
    endcase
  end

  assign inv_mask     = ~video_ctrl_q[3:1];
  assign plane_mask_o = (inv_mask == '0) ? '1 : inv_mask;
  assign flip_o       = cpu_ctrl_q[7];

  always_comb begin
    status_o.main_irq     = ~cpu_ctrl_q[2];
    status_o.sub_irq      = ~cpu_ctrl_q[1];
    status_o.frame_irq_en = ~cpu_ctrl_q[3];
    status_o.scroll_x     = scroll_x_q;
    status_o.scroll_y     = scroll_y_q;
    status_o.flip         = cpu_ctrl_q[7];
    status_o.blue_low     = video_ctrl_q[7];
  end

endmodule

>>> design/bitplane_bitmap_video_registers.sv
// A request is accepted in the idle state; EXEC registers its result, stalling while an
// older result is unread, and no request is taken in between. Bank read ports are read
// on accept and written back (bitmap write) or selected (pixel fetch) when EXEC ends.
// Reset: control registers clear at once; the bitmap is then cleared, all eight banks
// in parallel, with in_ready_o low. Configuration writes work throughout.
module bitplane_bitmap_video_registers import bbvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [15:0]        address_i,
  input  logic [7:0]         write_data_i,
  input  logic [7:0]         port_zero_i,
  input  logic [7:0]         port_one_i,
  input  logic [7:0]         port_two_i,
  input  logic               vblank_now_i,
  input  logic [7:0]         screen_x_i,
  input  logic [7:0]         screen_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         read_data_o,
  output logic [PIX_W-1:0]   pixel_value_o,
  output logic               main_irq_asserted_o,
  output logic               sub_irq_asserted_o,
  output logic               frame_irq_enable_o,
  output logic [8:0]         scroll_x_out_o,
  output logic [8:0]         scroll_y_out_o,
  output logic               flip_out_o,
  output logic               blue_low_bit_o
);

  state_e state_q, state_d;
  logic [BANK_AW-1:0] clr_cnt_q;
  logic accept, exec_done, clearing, clr_last;

  logic               plane_wr_q, fetch_q;
  logic [7:0]         wdata_q;
  logic [BANK_AW-1:0] lane_addr_q, lane_addr_acc;
  logic [LANE_SEL_W-1:0] bank_q;
  logic [7:0]         rdata_q;

  logic               out_valid_q;
  logic [7:0]         read_data_q;
  logic [PIX_W-1:0]   pixel_q;
  status_t            status_q;

  bus_req_t           bus_req;
  logic [7:0]         bus_rdata;
  logic [PIX_W-1:0]   plane_mask;
  logic               flip;
  status_t            status;
  lane_req_t          lane_req;
  logic [PIX_W-1:0]   lane_rd [NUM_LANES];
  logic [7:0]         fx, fy;
  op_e                op;

  assign op = op_e'(op_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  if (exec_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    clearing   = 1'b0;
    exec_done  = 1'b0;
    case (state_q)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_ready_o = 1'b1;
      ST_EXEC:  exec_done = ~out_valid_q | out_ready_i;
      default: ;
    endcase
  end

  assign accept   = in_valid_i & in_ready_o;
  assign clr_last = (clr_cnt_q == BANK_AW'(BANK_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // A flipped screen shows the bitmap mirrored in both directions.
  assign fx = flip ? ~screen_x_i : screen_x_i;
  assign fy = flip ? ~screen_y_i : screen_y_i;
  // Bank entry is row * 32 + column group; the bank is the low three column bits.
  assign lane_addr_acc = (op == OP_FETCH) ? {fy, fx[7:3]} : {address_i[7:0], address_i[12:8]};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      plane_wr_q  <= (op == OP_WRITE) && (address_i[15:13] == PLANE_PAGE);
      fetch_q     <= (op == OP_FETCH);
      wdata_q     <= write_data_i;
      lane_addr_q <= lane_addr_acc;
      bank_q      <= fx[LANE_SEL_W-1:0];
      rdata_q     <= (op == OP_READ) ? bus_rdata : 8'h00;
    end
  end

  always_comb begin
    bus_req.we    = accept && (op == OP_WRITE);
    bus_req.addr  = address_i;
    bus_req.wdata = write_data_i;
  end

  bbvr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .bus_req_i    (bus_req),
    .port_zero_i  (port_zero_i),
    .port_one_i   (port_one_i),
    .port_two_i   (port_two_i),
    .vblank_now_i (vblank_now_i),
    .bus_rdata_o  (bus_rdata),
    .plane_mask_o (plane_mask),
    .flip_o       (flip),
    .status_o     (status)
  );

  always_comb begin
    lane_req.rd_en   = accept;
    lane_req.rd_addr = lane_addr_acc;
    lane_req.wr_en   = clearing | (exec_done & plane_wr_q);
    lane_req.clr     = clearing;
    lane_req.wr_addr = clearing ? clr_cnt_q : lane_addr_q;
    lane_req.mask    = plane_mask;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bbvr_lane u_lane (
      .clk_i     (clk_i),
      .req_i     (lane_req),
      .bit_i     (wdata_q[g]),
      .rd_data_o (lane_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Merge: pick the bank holding the fetched column, and register read data and status.
  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      read_data_q <= rdata_q;
      pixel_q     <= fetch_q ? lane_rd[bank_q] : '0;
      status_q    <= status;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = read_data_q;
  assign pixel_value_o       = pixel_q;
  assign main_irq_asserted_o = status_q.main_irq;
  assign sub_irq_asserted_o  = status_q.sub_irq;
  assign frame_irq_enable_o  = status_q.frame_irq_en;
  assign scroll_x_out_o      = status_q.scroll_x;
  assign scroll_y_out_o      = status_q.scroll_y;
  assign flip_out_o          = status_q.flip;
  assign blue_low_bit_o      = status_q.blue_low;

endmodule

>>> design/bbvr_checker.sv
// Port-level checks of the bitplane bitmap video register block, bound to the top level.
module bbvr_checker import bbvr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         read_data_o,
  input logic [PIX_W-1:0]   pixel_value_o
);

  // An accepted request drops in_ready_o, so requests are never accepted back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted in back-to-back cycles");

  // A fresh result is always preceded by an accepted request, with the EXEC state between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a request two cycles earlier");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port inserted a wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(read_data_o) && $stable(pixel_value_o)))
    else $error("stalled result changed or dropped");

endmodule

bind bitplane_bitmap_video_registers bbvr_checker u_bbvr_checker (.*);
